// ----- rtl/ptln_pkg.sv -----
// ----------------------------------------------------------------------------
// ptln_pkg
// Types and constants shared by the parameter text line normalizer.
// ----------------------------------------------------------------------------
package ptln_pkg;

    localparam int unsigned LINE_MAX_DEF = 48;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_PCT   = 8'h25;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_UC_A  = 8'h41;
    localparam logic [7:0] CHR_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    localparam int unsigned SPC_W = 6;
    localparam logic [SPC_W-1:0] SPACE_SAT   = 6'd63;
    localparam logic [SPC_W-1:0] KEEP_SPACES = 6'd3;
    localparam logic [1:0] COLON_SAT  = 2'd2;
    localparam logic [1:0] KEEP_COLON = 2'd1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef enum logic [1:0] {
        CLS_NEWLINE,
        CLS_SPACE,
        CLS_OTHER
    } t_class;

    typedef enum logic [1:0] {
        PUT_NONE,
        PUT_ONE,
        PUT_COLON
    } t_put_kind;

    typedef struct packed {
        t_put_kind  kind;
        logic [7:0] data;
        logic       fin;
        logic       pad;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUT,
        BK_FIN,
        BK_EMIT
    } t_back_state;

endpackage

// ----- rtl/ptln_front.sv -----
// ----------------------------------------------------------------------------
// ptln_front
// Classifies each input byte and turns it into a line building command.
// ----------------------------------------------------------------------------
module ptln_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ptln_pkg::t_in  i_item,
    output logic           o_cmd_push,
    output ptln_pkg::t_cmd o_cmd
);

    ptln_pkg::t_class r_prev, n_prev;
    logic r_crp, n_crp;
    logic r_com, n_com;
    logic r_closed, n_closed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= ptln_pkg::CLS_NEWLINE;
            r_crp    <= 1'b0;
            r_com    <= 1'b0;
            r_closed <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_crp    <= n_crp;
            r_com    <= n_com;
            r_closed <= n_closed;
        end
    end

    always_comb begin
        logic [7:0] b;
        logic       consumed;
        logic       nl;
        b        = i_item.in_byte;
        consumed = 1'b0;
        nl       = 1'b0;
        n_prev   = r_prev;
        n_crp    = r_crp;
        n_com    = r_com;
        n_closed = r_closed;
        o_cmd    = '{kind: ptln_pkg::PUT_NONE, data: ptln_pkg::CHR_SPACE,
                     fin: 1'b0, pad: 1'b0};

        if (r_crp) begin
            n_crp = 1'b0;
            if (b == ptln_pkg::CHR_LF) begin
                nl       = 1'b1;
                consumed = 1'b1;
            end
        end

        if (!consumed) begin
            if (b == ptln_pkg::CHR_SPACE || b == ptln_pkg::CHR_TAB) begin
                if (r_prev == ptln_pkg::CLS_OTHER) begin
                    o_cmd.kind = ptln_pkg::PUT_ONE;
                    o_cmd.data = ptln_pkg::CHR_SPACE;
                    n_prev     = ptln_pkg::CLS_SPACE;
                end
            end else if (b == ptln_pkg::CHR_CR) begin
                n_crp = 1'b1;
            end else if (b == ptln_pkg::CHR_LF) begin
                nl = 1'b1;
            end else if (b == ptln_pkg::CHR_PCT) begin
                n_com = 1'b1;
            end else if (!r_com) begin
                n_closed = 1'b0;
                if (b == ptln_pkg::CHR_COLON) begin
                    o_cmd.kind = ptln_pkg::PUT_COLON;
                    n_prev     = ptln_pkg::CLS_SPACE;
                end else begin
                    o_cmd.kind = ptln_pkg::PUT_ONE;
                    if (b >= ptln_pkg::CHR_UC_A && b <= ptln_pkg::CHR_UC_Z) begin
                        o_cmd.data = b + ptln_pkg::CASE_OFS;
                    end else begin
                        o_cmd.data = b;
                    end
                    n_prev = ptln_pkg::CLS_OTHER;
                end
            end
        end

        // A line end closes the line unless one was just closed.
        o_cmd.pad = (n_prev != ptln_pkg::CLS_SPACE);
        if (nl) begin
            if (!r_closed) begin
                o_cmd.fin = 1'b1;
                n_prev    = ptln_pkg::CLS_NEWLINE;
                n_closed  = 1'b1;
            end
            n_com = 1'b0;
        end

        if (i_item.end_of_text) begin
            if (n_prev != ptln_pkg::CLS_NEWLINE) begin
                o_cmd.fin = 1'b1;
            end
            n_prev   = ptln_pkg::CLS_NEWLINE;
            n_crp    = 1'b0;
            n_com    = 1'b0;
            n_closed = 1'b0;
        end

        if (!i_valid) begin
            n_prev   = r_prev;
            n_crp    = r_crp;
            n_com    = r_com;
            n_closed = r_closed;
        end

        o_cmd_push = i_valid && (o_cmd.kind != ptln_pkg::PUT_NONE || o_cmd.fin);
    end

endmodule

// ----- rtl/ptln_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// ptln_cmd_queue
// Two-entry command queue between the classifier and the line engine.
// ----------------------------------------------------------------------------
module ptln_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptln_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output ptln_pkg::t_cmd o_data,
    output logic           o_empty
);

    ptln_pkg::t_cmd r_data [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/ptln_back.sv -----
// ----------------------------------------------------------------------------
// ptln_back
// Line engine: stores line bytes, judges each closed line and emits kept ones.
// ----------------------------------------------------------------------------
module ptln_back #(
    parameter int unsigned LINE_MAX = ptln_pkg::LINE_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_empty,
    input  ptln_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output ptln_pkg::t_out o_item
);

    localparam int unsigned AW    = $clog2(LINE_MAX);
    localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
    localparam int unsigned IDX_W = $clog2(LINE_MAX + 2);

    ptln_pkg::t_back_state r_state, n_state;
    ptln_pkg::t_cmd r_cmd, n_cmd;
    logic [1:0] r_put_idx, n_put_idx;
    logic [1:0] r_put_last, n_put_last;
    logic [LEN_W-1:0] r_len, n_len;
    logic [ptln_pkg::SPC_W-1:0] r_sp, n_sp;
    logic [1:0] r_col, n_col;
    logic r_ovf, n_ovf;
    logic [LEN_W-1:0] r_emit_len, n_emit_len;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    logic [7:0] r_mem [LINE_MAX];
    logic [7:0] r_mem_q;
    logic       mem_we;
    logic [7:0] mem_wd;
    logic       rd_en;
    logic [AW-1:0] rd_addr;

    logic       r_p_valid;
    logic       r_p_mem;
    logic [7:0] r_p_byte;
    logic       r_p_last;
    logic       n_p_mem;
    logic [7:0] n_p_byte;
    logic       n_p_last;

    ptln_pkg::t_out r_of_data [2];
    logic       r_of_wp;
    logic       r_of_rp;
    logic [1:0] r_of_cnt;
    logic       pop_fire;
    ptln_pkg::t_out of_in;

    assign pop_fire = i_pop && (r_of_cnt != 2'd0);
    assign o_empty  = (r_of_cnt == 2'd0);
    assign o_item   = r_of_data[r_of_rp];
    assign of_in    = '{out_byte: (r_p_mem ? r_mem_q : r_p_byte), out_last: r_p_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ptln_pkg::BK_IDLE;
            r_put_idx  <= 2'd0;
            r_put_last <= 2'd0;
            r_len      <= '0;
            r_sp       <= '0;
            r_col      <= 2'd0;
            r_ovf      <= 1'b0;
            r_emit_len <= '0;
            r_rd_idx   <= '0;
            r_p_valid  <= 1'b0;
            r_of_wp    <= 1'b0;
            r_of_rp    <= 1'b0;
            r_of_cnt   <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_put_idx  <= n_put_idx;
            r_put_last <= n_put_last;
            r_len      <= n_len;
            r_sp       <= n_sp;
            r_col      <= n_col;
            r_ovf      <= n_ovf;
            r_emit_len <= n_emit_len;
            r_rd_idx   <= n_rd_idx;
            r_p_valid  <= rd_en;
            if (r_p_valid) begin
                r_of_wp <= ~r_of_wp;
            end
            if (pop_fire) begin
                r_of_rp <= ~r_of_rp;
            end
            r_of_cnt <= r_of_cnt + {1'b0, r_p_valid} - {1'b0, pop_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (rd_en) begin
            r_p_mem  <= n_p_mem;
            r_p_byte <= n_p_byte;
            r_p_last <= n_p_last;
            r_mem_q  <= r_mem[rd_addr];
        end
        if (mem_we) begin
            r_mem[r_len[AW-1:0]] <= mem_wd;
        end
        if (r_p_valid) begin
            r_of_data[r_of_wp] <= of_in;
        end
    end

    always_comb begin
        logic [2:0] put_cnt;
        logic       keep;
        logic       room;
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_put_idx  = r_put_idx;
        n_put_last = r_put_last;
        n_len      = r_len;
        n_sp       = r_sp;
        n_col      = r_col;
        n_ovf      = r_ovf;
        n_emit_len = r_emit_len;
        n_rd_idx   = r_rd_idx;
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        mem_wd     = ptln_pkg::CHR_SPACE;
        rd_en      = 1'b0;
        rd_addr    = r_rd_idx[AW-1:0];
        n_p_mem    = 1'b0;
        n_p_byte   = ptln_pkg::CHR_CR;
        n_p_last   = 1'b0;
        put_cnt    = 3'd0;
        keep       = !r_ovf && r_sp == ptln_pkg::KEEP_SPACES
                     && r_col == ptln_pkg::KEEP_COLON;
        room       = ({1'b0, r_of_cnt} + {2'b0, r_p_valid}) < (3'd2 + {2'b0, pop_fire});

        unique case (r_state)
            ptln_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.kind)
                        ptln_pkg::PUT_ONE:   put_cnt = 3'd1;
                        ptln_pkg::PUT_COLON: put_cnt = 3'd3;
                        default:             put_cnt = 3'd0;
                    endcase
                    put_cnt    = put_cnt + {2'b0, i_cmd.fin && i_cmd.pad};
                    n_put_idx  = 2'd0;
                    n_put_last = 2'(put_cnt - 3'd1);
                    if (put_cnt != 3'd0) begin
                        n_state = ptln_pkg::BK_PUT;
                    end else if (i_cmd.fin) begin
                        n_state = ptln_pkg::BK_FIN;
                    end
                end
            end
            ptln_pkg::BK_PUT: begin
                if (r_cmd.kind == ptln_pkg::PUT_COLON) begin
                    mem_wd = (r_put_idx == 2'd1) ? ptln_pkg::CHR_COLON : ptln_pkg::CHR_SPACE;
                end else if (r_cmd.kind == ptln_pkg::PUT_ONE && r_put_idx == 2'd0) begin
                    mem_wd = r_cmd.data;
                end
                if (r_len < LEN_W'(LINE_MAX)) begin
                    mem_we = 1'b1;
                    n_len  = r_len + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                if (mem_wd == ptln_pkg::CHR_SPACE) begin
                    if (r_sp != ptln_pkg::SPACE_SAT) begin
                        n_sp = r_sp + 1'b1;
                    end
                end else if (mem_wd == ptln_pkg::CHR_COLON && r_col != ptln_pkg::COLON_SAT) begin
                    n_col = r_col + 1'b1;
                end
                n_put_idx = r_put_idx + 1'b1;
                if (r_put_idx == r_put_last) begin
                    n_state = r_cmd.fin ? ptln_pkg::BK_FIN : ptln_pkg::BK_IDLE;
                end
            end
            ptln_pkg::BK_FIN: begin
                n_emit_len = r_len;
                n_rd_idx   = '0;
                n_len      = '0;
                n_sp       = '0;
                n_col      = 2'd0;
                n_ovf      = 1'b0;
                n_state    = keep ? ptln_pkg::BK_EMIT : ptln_pkg::BK_IDLE;
            end
            ptln_pkg::BK_EMIT: begin
                if (room) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                    if (r_rd_idx < IDX_W'(r_emit_len)) begin
                        n_p_mem = 1'b1;
                    end else if (r_rd_idx == IDX_W'(r_emit_len)) begin
                        n_p_byte = ptln_pkg::CHR_CR;
                    end else begin
                        n_p_byte = ptln_pkg::CHR_LF;
                        n_p_last = 1'b1;
                        n_state  = ptln_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = ptln_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/param_text_line_normalizer.sv -----
// ----------------------------------------------------------------------------
// param_text_line_normalizer
// Normalizes parameter text one byte per transfer and emits kept lines.
// ----------------------------------------------------------------------------
// The engine writes a plain byte as is and a colon as space, colon and space;
// a line end adds a pad space if the line does not end in one, then closes it.
// A kept line is read out followed by CR and LF. The classifier takes new bytes
// while the engine works, until the two-entry command queue is full.
// Reset is synchronous and clears all control state; the line store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module param_text_line_normalizer #(
    parameter int unsigned LINE_MAX = ptln_pkg::LINE_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  ptln_pkg::t_in  i_in_item,
    output logic           empty,
    input  logic           pop,
    output ptln_pkg::t_out o_out_item
);

    logic           accept;
    logic           cmd_push;
    ptln_pkg::t_cmd cmd_in;
    ptln_pkg::t_cmd cmd_out;
    logic           cmd_pop;
    logic           cmd_empty;

    assign accept = push && !full;

    ptln_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_item     (i_in_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    ptln_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    ptln_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule
